@@ hw/rtl/sh13_pkg.sv @@
// Shared types, constants and round functions for the SipHash-1-3 core.
package sh13_pkg;

    // Default depth of the operation queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 4;

    // Configuration register indexes.
    localparam int unsigned CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_LOW  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_HIGH = 1'b1;

    // Chain word initialization constants.
    localparam logic [63:0] INIT_V0 = 64'h736f6d6570736575;
    localparam logic [63:0] INIT_V1 = 64'h646f72616e646f6d;
    localparam logic [63:0] INIT_V2 = 64'h6c7967656e657261;
    localparam logic [63:0] INIT_V3 = 64'h7465646279746573;

    // Finalization constant and position of the length byte.
    localparam logic [63:0] FINAL_XOR = 64'hff;
    localparam int unsigned LEN_SHIFT = 56;

    // Bytes in one message word.
    localparam logic [3:0] WORD_BYTES = 4'd8;

    // The four chain words.
    typedef struct packed {
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
    } chain_t;

    // One queued operation: a classified input beat.
    typedef struct packed {
        logic        start;        // first beat of a message: reload chain
        logic        last;         // final beat: run block and finalization
        logic        absorb_word;  // absorb the whole word as a block
        logic [63:0] word;         // message word
        logic [63:0] block;        // final block: length byte and tail bytes
    } sh13_op_t;

    // Rotate left by a constant amount.
    function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
        return (x << r) | (x >> (64 - r));
    endfunction

    // One SipRound.
    function automatic chain_t sip_round(input chain_t v);
        chain_t w;
        w = v;
        w.v0 = w.v0 + w.v1; w.v1 = rotl(w.v1, 13); w.v1 = w.v1 ^ w.v0;
        w.v0 = rotl(w.v0, 32);
        w.v2 = w.v2 + w.v3; w.v3 = rotl(w.v3, 16); w.v3 = w.v3 ^ w.v2;
        w.v0 = w.v0 + w.v3; w.v3 = rotl(w.v3, 21); w.v3 = w.v3 ^ w.v0;
        w.v2 = w.v2 + w.v1; w.v1 = rotl(w.v1, 17); w.v1 = w.v1 ^ w.v2;
        w.v2 = rotl(w.v2, 32);
        return w;
    endfunction

    // Absorb one 64-bit block with a single round.
    function automatic chain_t absorb(input chain_t v, input logic [63:0] m);
        chain_t w;
        w = v;
        w.v3 = w.v3 ^ m;
        w = sip_round(w);
        w.v0 = w.v0 ^ m;
        return w;
    endfunction

    // Chain words at the start of a message.
    function automatic chain_t init_chain(input logic [63:0] k0, input logic [63:0] k1);
        chain_t w;
        w.v0 = INIT_V0 ^ k0;
        w.v1 = INIT_V1 ^ k1;
        w.v2 = INIT_V2 ^ k0;
        w.v3 = INIT_V3 ^ k1;
        return w;
    endfunction

endpackage

@@ hw/rtl/sh13_front.sv @@
// Front end: accepts message beats, tracks the message length and builds operations.
module sh13_front import sh13_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] word_in,
    input  logic [3:0]  valid_bytes_in,
    input  logic        last_in,
    output logic        op_valid,
    input  logic        op_ready,
    output sh13_op_t    op_out
);

    logic       in_msg_reg;
    logic       in_msg_next;
    logic [7:0] byte_count_reg;
    logic [7:0] byte_count_next;
    logic       accept;
    logic [3:0] vb_sat;
    logic [7:0] count_base;
    logic [7:0] count_new;
    logic [63:0] tail;

    assign s_tready = op_ready;
    assign op_valid = s_tvalid;
    assign accept   = s_tvalid && op_ready;

    // Length bookkeeping and final block construction.
    always_comb begin
        vb_sat     = (valid_bytes_in > WORD_BYTES) ? WORD_BYTES : valid_bytes_in;
        count_base = in_msg_reg ? byte_count_reg : 8'd0;
        if (last_in) begin
            count_new = count_base + {4'd0, vb_sat};
        end else begin
            count_new = count_base + {4'd0, WORD_BYTES};
        end
        if (vb_sat == WORD_BYTES) begin
            tail = 64'd0;
        end else begin
            tail = word_in & ((64'd1 << {vb_sat[2:0], 3'b000}) - 64'd1);
        end
        op_out.start       = !in_msg_reg;
        op_out.last        = last_in;
        op_out.absorb_word = !last_in || (vb_sat == WORD_BYTES);
        op_out.word        = word_in;
        op_out.block       = (64'(count_new) << LEN_SHIFT) | tail;
        in_msg_next        = accept ? !last_in : in_msg_reg;
        byte_count_next    = accept ? count_new : byte_count_reg;
    end

    // Message tracking registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_msg_reg     <= 1'b0;
            byte_count_reg <= 8'd0;
        end else begin
            in_msg_reg     <= in_msg_next;
            byte_count_reg <= byte_count_next;
        end
    end

    // A last beat closes the message.
    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && last_in) |=> !in_msg_reg)
        else $error("message still open after last beat");

endmodule

@@ hw/rtl/sh13_queue.sv @@
// Short operation queue between the front end and the round engine.
module sh13_queue import sh13_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push_valid,
    output logic     push_ready,
    input  sh13_op_t push_op,
    output logic     pop_valid,
    input  logic     pop_ready,
    output sh13_op_t pop_op
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    sh13_op_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("queue occupancy beyond depth");

    a_count_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue count did not follow a push");

endmodule

@@ hw/rtl/sh13_back.sv @@
// Round engine: runs queued ops one round per cycle unless stalled; holds result.
module sh13_back import sh13_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [63:0] key_low,
    input  logic [63:0] key_high,
    input  logic        op_valid,
    output logic        op_ready,
    input  sh13_op_t    op_in,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] hash_out
);

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_BLOCK,
        PH_R1,
        PH_R2,
        PH_R3
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    chain_t      v_reg;
    chain_t      v_next;
    chain_t      base;
    chain_t      fin;
    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic [63:0] hash_reg;
    logic [63:0] hash_next;
    logic        out_busy;
    logic        advance;

    assign out_busy = m_tvalid_reg && !m_tready;
    assign advance  = op_valid && !((phase_reg == PH_R3) && out_busy);
    assign m_tvalid = m_tvalid_reg;
    assign hash_out = hash_reg;

    // Step selection for the operation at the head of the queue.
    always_comb begin
        base = (op_in.start && (phase_reg == PH_FIRST)) ? init_chain(key_low, key_high)
                                                        : v_reg;
        fin       = absorb(base, op_in.block);
        fin.v2    = fin.v2 ^ FINAL_XOR;
        v_next    = v_reg;
        phase_next = phase_reg;
        op_ready  = 1'b0;
        hash_next = hash_reg;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        if (advance) begin
            case (phase_reg)
                PH_FIRST: begin
                    if (op_in.absorb_word) begin
                        v_next = absorb(base, op_in.word);
                        if (op_in.last) begin
                            phase_next = PH_BLOCK;
                        end else begin
                            op_ready = 1'b1;
                        end
                    end else begin
                        v_next     = fin;
                        phase_next = PH_R1;
                    end
                end
                PH_BLOCK: begin
                    v_next     = fin;
                    phase_next = PH_R1;
                end
                PH_R1: begin
                    v_next     = sip_round(v_reg);
                    phase_next = PH_R2;
                end
                PH_R2: begin
                    v_next     = sip_round(v_reg);
                    phase_next = PH_R3;
                end
                PH_R3: begin
                    v_next        = sip_round(v_reg);
                    hash_next     = v_next.v0 ^ v_next.v1 ^ v_next.v2 ^ v_next.v3;
                    m_tvalid_next = 1'b1;
                    op_ready      = 1'b1;
                    phase_next    = PH_FIRST;
                end
                default: begin
                    phase_next = PH_FIRST;
                end
            endcase
        end
    end

    // Phase, chain words and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_FIRST;
            m_tvalid_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            m_tvalid_reg <= m_tvalid_next;
            v_reg        <= v_next;
            hash_reg     <= hash_next;
        end
    end

    // Mid-operation phases always have their operation still queued.
    a_phase_has_op: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_FIRST) |-> op_valid)
        else $error("round engine mid-operation without a queued entry");

    // A new result only comes out of the last finalization round.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !$past(m_tvalid_reg)) |-> $past(phase_reg == PH_R3))
        else $error("result raised outside the last round");

    // A held result is not overwritten.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> (m_tvalid_reg && $stable(hash_reg)))
        else $error("stalled result changed");

endmodule

@@ hw/rtl/siphash13_keyed_hash_core.sv @@
// Top level of the keyed SipHash-1-3 core: key registers, front end, queue and round engine.
//
//  Channel  Direction  Beat contents
//  s_       in         tdata[63:0] message_word, tdata[67:64] valid_bytes; tlast last_word
//  m_       out        tdata[63:0] hash_value
//  cfg_     in         cfg_addr 0 key_low, 1 key_high; cfg_wdata 64-bit key word
//
// A word that is not last leaves the round engine once it is absorbed; a last word stays
// there through the word absorb when it carries eight valid bytes, the block absorb and three rounds.
// The single round engine sets the rate; the operation queue lets the front keep taking
// beats while the engine finalizes or while a result waits in the output register.
// Reset is synchronous and active low; keys reset to zero and no clearing pass is needed.
// Keys are read when a message's first word reaches the round engine.
module siphash13_keyed_hash_core import sh13_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [71:0]           s_tdata,   // [63:0] message_word, [67:64] valid_bytes, [71:68] zero
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [63:0]           m_tdata,   // [63:0] hash_value
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [63:0]           cfg_wdata
);

    logic [63:0] key_low_reg;
    logic [63:0] key_high_reg;
    logic        fq_valid;
    logic        fq_ready;
    sh13_op_t    fq_op;
    logic        qb_valid;
    logic        qb_ready;
    sh13_op_t    qb_op;

    // Key registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= 64'd0;
            key_high_reg <= 64'd0;
        end else if (cfg_wr_en) begin
            if (cfg_addr == REG_KEY_LOW) begin
                key_low_reg <= cfg_wdata;
            end
            if (cfg_addr == REG_KEY_HIGH) begin
                key_high_reg <= cfg_wdata;
            end
        end
    end

    sh13_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .word_in        (s_tdata[63:0]),
        .valid_bytes_in (s_tdata[67:64]),
        .last_in        (s_tlast),
        .op_valid       (fq_valid),
        .op_ready       (fq_ready),
        .op_out         (fq_op)
    );

    sh13_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_op    (fq_op),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_op     (qb_op)
    );

    sh13_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .key_low  (key_low_reg),
        .key_high (key_high_reg),
        .op_valid (qb_valid),
        .op_ready (qb_ready),
        .op_in    (qb_op),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .hash_out (m_tdata)
    );

endmodule

@@ dv/tb_siphash13_keyed_hash_core.sv @@
// Self-checking testbench for the keyed SipHash-1-3 core: directed table, random messages.
module tb_siphash13_keyed_hash_core;
    import sh13_pkg::*;

    localparam int unsigned CLK_HALF     = 2;
    localparam int unsigned RESET_CYCLES = 8;
    localparam int unsigned SETTLE       = 24;
    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned SEGMENTS     = 6;
    localparam int unsigned SEG_WORDS    = 125;

    // One message word as the sender presents it.
    typedef struct {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        last;
    } msg_beat_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [71:0]           s_tdata;   // [63:0] message_word, [67:64] valid_bytes, [71:68] zero
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [63:0]           m_tdata;   // [63:0] hash_value
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [63:0]           cfg_wdata;

    siphash13_keyed_hash_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Predictor state: key copies, the four lanes, running length and message flag.
    logic [63:0] key_lo_q;
    logic [63:0] key_hi_q;
    logic [63:0] lanes [4];
    logic [7:0]  msg_len;
    logic        msg_open;

    // Hashes still owed by the core, oldest first.
    logic [63:0] pending_hashes [$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned msgs_sent;
    int unsigned words_sent;
    int unsigned hashes_checked;
    int unsigned key_settings;

    // Directed table: extremes of the word, every valid-byte count from 0 to 8 and the special cases.
    msg_beat_t directed_rows [] = '{
        '{64'hffff_ffff_ffff_ffff, 4'd0,  1'b1},  // empty last word, bits ignored
        '{64'hffff_ffff_ffff_ffff, 4'd1,  1'b1},  // upper seven bytes masked
        '{64'hffff_ffff_ffff_ffff, 4'd7,  1'b1},
        '{64'hffff_ffff_ffff_ffff, 4'd8,  1'b1},  // full last word
        '{64'hffff_ffff_ffff_ffff, 4'd9,  1'b1},  // count saturates to eight
        '{64'h0123_4567_89ab_cdef, 4'd15, 1'b1},
        '{64'h0000_0000_0000_0000, 4'd0,  1'b1},
        '{64'h0000_0000_0000_0000, 4'd3,  1'b0},  // count ignored on a non-last word
        '{64'h8899_aabb_ccdd_eeff, 4'd4,  1'b1},
        '{64'hffff_ffff_ffff_ffff, 4'd0,  1'b0},
        '{64'h8000_0000_0000_0000, 4'd15, 1'b0},
        '{64'h0000_0000_0000_0001, 4'd8,  1'b1},
        '{64'h0706_0504_0302_0100, 4'd2,  1'b1},
        '{64'h0706_0504_0302_0100, 4'd3,  1'b1},
        '{64'h0706_0504_0302_0100, 4'd4,  1'b1},
        '{64'h0706_0504_0302_0100, 4'd5,  1'b1},
        '{64'h0706_0504_0302_0100, 4'd6,  1'b1}
    };

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #(CLK_HALF) aclk = ~aclk;
    end

    // Run limit.
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Run limit of %0d cycles reached with %0d hashes outstanding.",
                     LIMIT_CYCLES, pending_hashes.size());
            $display("siphash13_keyed_hash_core test failed");
            $finish;
        end
    end

    function automatic logic [63:0] rol64(input logic [63:0] x, input int unsigned r);
        return (x << r) | (x >> (64 - r));
    endfunction

    // One SipRound over the predictor lanes.
    function automatic void sip_mix();
        lanes[0] = lanes[0] + lanes[1]; lanes[1] = rol64(lanes[1], 13);
        lanes[1] = lanes[1] ^ lanes[0]; lanes[0] = rol64(lanes[0], 32);
        lanes[2] = lanes[2] + lanes[3]; lanes[3] = rol64(lanes[3], 16);
        lanes[3] = lanes[3] ^ lanes[2];
        lanes[0] = lanes[0] + lanes[3]; lanes[3] = rol64(lanes[3], 21);
        lanes[3] = lanes[3] ^ lanes[0];
        lanes[2] = lanes[2] + lanes[1]; lanes[1] = rol64(lanes[1], 17);
        lanes[1] = lanes[1] ^ lanes[2]; lanes[2] = rol64(lanes[2], 32);
    endfunction

    function automatic void fold_block(input logic [63:0] m);
        lanes[3] = lanes[3] ^ m;
        sip_mix();
        lanes[0] = lanes[0] ^ m;
    endfunction

    // Advance the hash predictor by one accepted word; a last word queues its hash.
    function automatic void hash_predict(input msg_beat_t b);
        logic [3:0]  take;
        logic [63:0] tail;
        if (!msg_open) begin
            lanes[0] = INIT_V0 ^ key_lo_q;
            lanes[1] = INIT_V1 ^ key_hi_q;
            lanes[2] = INIT_V2 ^ key_lo_q;
            lanes[3] = INIT_V3 ^ key_hi_q;
            msg_len  = 8'd0;
            msg_open = 1'b1;
        end
        if (!b.last) begin
            fold_block(b.word);
            msg_len = msg_len + 8'(WORD_BYTES);
        end else begin
            take = (b.nbytes > WORD_BYTES) ? WORD_BYTES : b.nbytes;
            msg_len = msg_len + 8'(take);
            tail = 64'd0;
            if (take == WORD_BYTES)
                fold_block(b.word);
            else if (take != 4'd0)
                tail = b.word & ((64'd1 << (8 * take)) - 64'd1);
            fold_block((64'(msg_len) << LEN_SHIFT) | tail);
            lanes[2] = lanes[2] ^ FINAL_XOR;
            sip_mix();
            sip_mix();
            sip_mix();
            pending_hashes.push_back(lanes[0] ^ lanes[1] ^ lanes[2] ^ lanes[3]);
            msg_open = 1'b0;
            msgs_sent++;
        end
    endfunction

    // Present one beat at the falling edge and hold it until the core takes it.
    task automatic send_beat(input msg_beat_t b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {4'd0, b.nbytes, b.word};
        s_tlast  = b.last;
        do @(posedge aclk); while (!s_tready);
        hash_predict(b);
        words_sent++;
        @(negedge aclk);
    endtask

    // Wait until every owed hash is back, then let the engine settle.
    task automatic drain_core();
        s_tvalid = 1'b0;
        while (pending_hashes.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // Load both key registers while the core is idle.
    task automatic load_keys(input logic [63:0] k_lo, input logic [63:0] k_hi);
        cfg_wr_en = 1'b1;
        cfg_addr  = REG_KEY_LOW;
        cfg_wdata = k_lo;
        key_lo_q  = k_lo;
        @(negedge aclk);
        cfg_addr  = REG_KEY_HIGH;
        cfg_wdata = k_hi;
        key_hi_q  = k_hi;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        key_settings++;
    endtask

    function automatic logic [63:0] rand_word();
        logic [63:0] one_hot;
        one_hot = 64'd1 << $urandom_range(63);
        case ($urandom_range(9))
            0:       return 64'd0;
            1:       return '1;
            2:       return one_hot;
            3:       return ~one_hot;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // One random message; long ones can push the byte count past 255.
    task automatic send_message(input bit long_msg);
        int unsigned n_words;
        msg_beat_t   b;
        n_words = long_msg ? $urandom_range(40, 31) : $urandom_range(6, 1);
        for (int unsigned i = 0; i < n_words; i++) begin
            b.word = rand_word();
            b.last = (i == n_words - 1);
            if (!b.last)
                b.nbytes = 4'($urandom_range(15));
            else if ($urandom_range(3) == 0)
                b.nbytes = 4'($urandom_range(15));
            else
                b.nbytes = 4'($urandom_range(8));
            send_beat(b);
        end
    endtask

    // Result side: random back-pressure at the falling edge.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each hash beat with the oldest prediction.
    always @(posedge aclk) begin
        logic [63:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_hashes.size() == 0) begin
                $error("hash_value beat with none expected: actual %h", m_tdata);
                error_count++;
            end else begin
                want = pending_hashes.pop_front();
                hashes_checked++;
                if (m_tdata !== want) begin
                    $error("hash_value mismatch: expected %h, actual %h", want, m_tdata);
                    error_count++;
                end
            end
        end
    end

    // Stimulus.
    initial begin
        logic [63:0] k_lo;
        logic [63:0] k_hi;
        int unsigned seg_start;
        int unsigned msg_idx;

        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_addr       = REG_KEY_LOW;
        cfg_wdata      = '0;
        key_lo_q       = '0;
        key_hi_q       = '0;
        msg_len        = '0;
        msg_open       = 1'b0;
        error_count    = 0;
        msgs_sent      = 0;
        words_sent     = 0;
        hashes_checked = 0;
        key_settings   = 1;
        send_idle_pct  = 6;
        recv_idle_pct  = 75;
        foreach (lanes[i]) lanes[i] = '0;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed table with the reset keys.
        foreach (directed_rows[i])
            send_beat(directed_rows[i]);

        // Random part: two key settings per back-pressure phase.
        for (int unsigned seg = 0; seg < SEGMENTS; seg++) begin
            case (seg / 2)
                0: begin send_idle_pct = 6;  recv_idle_pct = 75; end
                1: begin send_idle_pct = 75; recv_idle_pct = 6;  end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            case (seg)
                0:       begin k_lo = '1;    k_hi = '1;    end
                1:       begin k_lo = '0;    k_hi = '1;    end
                3:       begin k_lo = '1;    k_hi = '0;    end
                default: begin k_lo = {$urandom, $urandom}; k_hi = {$urandom, $urandom}; end
            endcase
            drain_core();
            load_keys(k_lo, k_hi);
            seg_start = words_sent;
            msg_idx   = 0;
            while (words_sent - seg_start < SEG_WORDS) begin
                send_message(msg_idx == 0 || $urandom_range(24) == 0);
                msg_idx++;
            end
        end

        drain_core();
        if (pending_hashes.size() != 0) begin
            $error("%0d hash_value results never arrived", pending_hashes.size());
            error_count++;
        end

        $display("Sent %0d words in %0d messages under %0d key settings and three",
                 words_sent, msgs_sent, key_settings);
        $display("back-pressure mixes; %0d hashes compared, %0d errors.",
                 hashes_checked, error_count);
        if (error_count == 0)
            $display("siphash13_keyed_hash_core test passed");
        else
            $display("siphash13_keyed_hash_core test failed");
        $finish;
    end

endmodule
